// ----- src/dht_pkg.sv -----
package dht_pkg;

    localparam int DHT_DEPTH = 1024;
    localparam int NW        = 11;    // slot count / index arithmetic width
    localparam int KW        = 32;    // key and value width
    localparam int RW        = 2 * KW + 1;  // ram word: {occupied, key, value}

    localparam logic [1:0] OP_SEARCH = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic [NW-1:0] SIZE_RESET = 11'd1021;

    typedef struct packed {
        logic [1:0]    op;
        logic [KW-1:0] key;
        logic [KW-1:0] value;
        logic [NW-1:0] start;
        logic [NW-1:0] step;
    } job_t;

endpackage

// ----- src/dht_ifs.sv -----
interface dht_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] key;
    logic [31:0] value;

    modport source (output valid, operation, key, value, input ready);
    modport sink   (input valid, operation, key, value, output ready);
endinterface

interface dht_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [9:0]  slot;

    modport source (output valid, status, found_value, slot, input ready);
    modport sink   (input valid, status, found_value, slot, output ready);
endinterface

interface dht_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- src/dht_ram.sv -----
module dht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/dht_queue.sv -----
module dht_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dht_pkg::job_t push_job,
    output logic          can_push,
    input  logic          pop,
    output dht_pkg::job_t pop_job,
    output logic          can_pop
);
    import dht_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign can_push = (cnt_reg != 2'd2);
    assign can_pop  = (cnt_reg != 2'd0);
    assign pop_job  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && can_push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop && can_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if ((push && can_push) && !(pop && can_pop))
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!(push && can_push) && (pop && can_pop))
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && can_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- src/dht_front.sv -----
module dht_front (
    input  logic                    clk,
    input  logic                    rst_n,
    dht_req_if.sink                 req,
    input  logic [dht_pkg::NW-1:0]  n,
    input  logic                    clearing,
    output logic                    push,
    output dht_pkg::job_t           push_job,
    input  logic                    can_push
);
    import dht_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t       state_reg, state_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [1:0]    op_reg;
    logic [KW-1:0] key_reg;
    logic [KW-1:0] value_reg;
    logic [KW-1:0] sh_reg;
    logic [NW-1:0] rem_a_reg, rem_a_next;
    logic [NW-1:0] rem_b_reg, rem_b_next;

    logic [NW:0] ta, tb, da, db;

    // one quotient bit per cycle for both remainders
    always_comb
    begin
        da = {1'b0, n};
        db = {1'b0, n - NW'(1)};
        ta = {rem_a_reg, sh_reg[KW-1]};
        tb = {rem_b_reg, sh_reg[KW-1]};
        rem_a_next = (ta >= da) ? NW'(ta - da) : NW'(ta);
        rem_b_next = (tb >= db) ? NW'(tb - db) : NW'(tb);
    end

    assign req.ready      = (state_reg == F_IDLE) && !clearing;
    assign push           = (state_reg == F_PUSH);
    assign push_job.op    = op_reg;
    assign push_job.key   = key_reg;
    assign push_job.value = value_reg;
    assign push_job.start = rem_a_reg;
    assign push_job.step  = rem_b_reg + NW'(1);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    state_next = F_DIV;
                    cnt_next   = 5'd0;
                end
            end
            F_DIV:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (can_push)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg    <= req.operation;
            key_reg   <= req.key;
            value_reg <= req.value;
            sh_reg    <= req.key;
            rem_a_reg <= '0;
            rem_b_reg <= '0;
        end
        else if (state_reg == F_DIV)
        begin
            sh_reg    <= {sh_reg[KW-2:0], 1'b0};
            rem_a_reg <= rem_a_next;
            rem_b_reg <= rem_b_next;
        end
    end

endmodule

// ----- src/dht_back.sv -----
module dht_back #(
    parameter int DEPTH = dht_pkg::DHT_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [dht_pkg::NW-1:0] n,
    output logic                   clearing,
    input  dht_pkg::job_t          job,
    input  logic                   can_pop,
    output logic                   pop,
    dht_rsp_if.source              rsp
);
    import dht_pkg::*;

    localparam int AW = $clog2(DEPTH);

    typedef enum logic [5:0] {
        B_CLR  = 6'b000001,
        B_IDLE = 6'b000010,
        B_RD   = 6'b000100,
        B_CHK  = 6'b001000,
        B_WR   = 6'b010000,
        B_OUT  = 6'b100000
    } bstate_t;

    bstate_t       state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    job_t          job_reg;
    logic [NW-1:0] idx_reg, idx_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          free_seen_reg, free_seen_next;
    logic [NW-1:0] free_idx_reg, free_idx_next;
    logic [1:0]    res_st_reg, res_st_next;
    logic [KW-1:0] res_val_reg, res_val_next;
    logic [NW-1:0] res_slot_reg, res_slot_next;
    logic          wr_occ_reg, wr_occ_next;
    logic [NW-1:0] wr_idx_reg, wr_idx_next;
    logic          out_valid_reg;
    logic [1:0]    out_st_reg;
    logic [KW-1:0] out_val_reg;
    logic [9:0]    out_slot_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [RW-1:0] wdata;
    logic [RW-1:0] rdata;
    logic          r_occ;
    logic [KW-1:0] r_key;
    logic [KW-1:0] r_val;
    logic          hit;
    logic [NW:0]   sum;
    logic          load_out;

    dht_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (AW'(idx_reg)),
        .rdata (rdata)
    );

    assign r_occ    = rdata[RW-1];
    assign r_key    = rdata[2*KW-1:KW];
    assign r_val    = rdata[KW-1:0];
    assign hit      = r_occ && (r_key == job_reg.key);
    assign sum      = {1'b0, idx_reg} + {1'b0, job_reg.step};
    assign clearing = (state_reg == B_CLR);
    assign pop      = (state_reg == B_IDLE) && can_pop;
    assign load_out = (state_reg == B_OUT) && (!out_valid_reg || rsp.ready);

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_st_reg;
    assign rsp.found_value = out_val_reg;
    assign rsp.slot        = out_slot_reg;

    always_comb
    begin
        we    = 1'b0;
        waddr = AW'(wr_idx_reg);
        wdata = {wr_occ_reg, job_reg.key, job_reg.value};
        if (state_reg == B_CLR)
        begin
            we    = 1'b1;
            waddr = clr_reg;
            wdata = '0;
        end
        else if (state_reg == B_WR)
        begin
            we = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        free_seen_next = free_seen_reg;
        free_idx_next  = free_idx_reg;
        res_st_next    = res_st_reg;
        res_val_next   = res_val_reg;
        res_slot_next  = res_slot_reg;
        wr_occ_next    = wr_occ_reg;
        wr_idx_next    = wr_idx_reg;
        unique case (state_reg)
            B_CLR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (can_pop)
                begin
                    idx_next       = job.start;
                    cnt_next       = '0;
                    free_seen_next = 1'b0;
                    state_next     = B_RD;
                end
            end
            B_RD:
            begin
                state_next = B_CHK;
            end
            B_CHK:
            begin
                if (!free_seen_reg && !r_occ)
                begin
                    free_seen_next = 1'b1;
                    free_idx_next  = idx_reg;
                end
                res_st_next   = ST_NOT_FOUND;
                res_val_next  = '0;
                res_slot_next = '0;
                if (hit || (cnt_reg == n - NW'(1)))
                begin
                    state_next = B_OUT;
                    unique case (job_reg.op)
                        OP_SEARCH:
                        begin
                            if (hit)
                            begin
                                res_st_next   = ST_OK;
                                res_val_next  = r_val;
                                res_slot_next = idx_reg;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (hit)
                            begin
                                res_st_next   = ST_DUPLICATE;
                                res_slot_next = idx_reg;
                            end
                            else if (free_seen_next)
                            begin
                                res_st_next   = ST_OK;
                                res_slot_next = free_idx_next;
                                wr_occ_next   = 1'b1;
                                wr_idx_next   = free_idx_next;
                                state_next    = B_WR;
                            end
                            else
                            begin
                                res_st_next = ST_FULL;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (hit)
                            begin
                                res_st_next   = ST_OK;
                                res_slot_next = idx_reg;
                                wr_occ_next   = 1'b0;
                                wr_idx_next   = idx_reg;
                                state_next    = B_WR;
                            end
                        end
                        default:
                        begin
                            res_st_next = ST_NOT_FOUND;
                        end
                    endcase
                end
                else
                begin
                    cnt_next   = cnt_reg + NW'(1);
                    idx_next   = (sum >= {1'b0, n}) ? NW'(sum - {1'b0, n}) : NW'(sum);
                    state_next = B_RD;
                end
            end
            B_WR:
            begin
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (load_out)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= job;
        end
        idx_reg       <= idx_next;
        cnt_reg       <= cnt_next;
        free_seen_reg <= free_seen_next;
        free_idx_reg  <= free_idx_next;
        res_st_reg    <= res_st_next;
        res_val_reg   <= res_val_next;
        res_slot_reg  <= res_slot_next;
        wr_occ_reg    <= wr_occ_next;
        wr_idx_reg    <= wr_idx_next;
        if (load_out)
        begin
            out_st_reg   <= res_st_reg;
            out_val_reg  <= res_val_reg;
            out_slot_reg <= res_slot_reg[9:0];
        end
    end

endmodule

// ----- src/double_hash_table_core.sv -----
// Open-addressing key/value table with double hashing.
//
// Channels: req carries operation (search, insert, delete), key and value;
// rsp returns one result per request: status, found_value and slot. A
// transfer happens on a clock edge with valid and ready both high. cfg
// writes table_size (slots in use, saturated to 3..DEPTH) while idle; the
// user keeps to this, the block itself does not enforce it.
//
// The front divides one remainder bit per cycle for key mod n and key mod
// (n-1): a 32-step restoring division, one compare and subtract for each
// remainder on a shared key shift. The back probes with a registered ram
// read, then a compare, walking up to n probes; a hit stops early, a miss
// or an insert of a new key walks the whole chain. Around the walk it takes
// the job from the queue, writes the table when the item changes it and
// loads the output register. Throughput is set by the slower of the two.
// A two-entry job queue lets the front divide while the back probes.
//
// Reset: the back sweeps the ram clearing the occupied marks, and req.ready
// stays low until that pass ends. cfg is taken at any time. Receiver stall:
// the result waits in the output register; the back holds its next result,
// and the front and queue keep taking requests until full.
module double_hash_table_core #(
    parameter int DEPTH = dht_pkg::DHT_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    dht_req_if.sink   req,
    dht_rsp_if.source rsp,
    dht_cfg_if.sink   cfg
);
    import dht_pkg::*;

    logic [NW-1:0] size_reg;
    logic [NW-1:0] n;          // slots in use, saturated
    logic          clearing;
    logic          push, can_push, pop, can_pop;
    job_t          push_job, pop_job;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            size_reg <= cfg.data;
        end
    end

    always_comb
    begin
        if (size_reg < NW'(3))
        begin
            n = NW'(3);
        end
        else if ({21'b0, size_reg} > 32'(DEPTH))
        begin
            n = NW'(DEPTH);
        end
        else
        begin
            n = size_reg;
        end
    end

    dht_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .n        (n),
        .clearing (clearing),
        .push     (push),
        .push_job (push_job),
        .can_push (can_push)
    );

    dht_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .can_push (can_push),
        .pop      (pop),
        .pop_job  (pop_job),
        .can_pop  (can_pop)
    );

    dht_back #(.DEPTH(DEPTH)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .n        (n),
        .clearing (clearing),
        .job      (pop_job),
        .can_pop  (can_pop),
        .pop      (pop),
        .rsp      (rsp)
    );

endmodule

// ----- src/dht_checker.sv -----
module dht_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [31:0] rsp_found_value,
    input logic [9:0]  rsp_slot
);
    import dht_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_slot))
        else $error("rsp changed while stalled");

    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_NOT_FOUND || rsp_status == ST_FULL)
        |-> rsp_slot == 10'd0 && rsp_found_value == 32'd0)
        else $error("miss result carries data");

    a_dup: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_DUPLICATE |-> rsp_found_value == 32'd0)
        else $error("duplicate result carries value");

endmodule

bind double_hash_table_core dht_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_found_value (rsp.found_value),
    .rsp_slot        (rsp.slot)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import dht_pkg::*;

    localparam int SLOTS      = 1024;
    localparam int IDLE_LIMIT = 60000;   // longest chain walk plus stalls, several times over
    localparam int SHOW_MAX   = 10;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] value;
    } lookup_req_t;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic [9:0]  slot;
    } lookup_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dht_req_if req_ch ();
    dht_rsp_if rsp_ch ();
    dht_cfg_if cfg_ch ();

    double_hash_table_core dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #2 clk = ~clk;

    // Mirror of the table contents, updated as each request transfer is seen.
    bit          mir_used [SLOTS];
    logic [31:0] mir_key [SLOTS];
    logic [31:0] mir_val [SLOTS];
    int unsigned mir_count;
    logic [10:0] mir_size = SIZE_RESET;

    lookup_req_t pending_reqs[$];
    lookup_rsp_t expected_rsps[$];

    int  n_req, n_rsp, n_bad, n_full, n_dup, n_miss, n_hit;
    int  req_gap, rsp_stall;
    bit  idle_on;   // cleared for stretches with no idling at all
    int  quiet_cycles;

    function automatic int unsigned slots_in_use();
        int unsigned n;
        n = mir_size;
        if (n < 3) n = 3;
        if (n > SLOTS) n = SLOTS;
        return n;
    endfunction

    // Walk the key's probe chain: want_free picks the first empty slot,
    // otherwise the first occupied slot holding the key.
    function automatic bit probe_chain(logic [31:0] key, bit want_free,
                                       output int unsigned where);
        int unsigned n, idx, stride;
        n      = slots_in_use();
        idx    = key % n;
        stride = 1 + key % (n - 1);
        where  = 0;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (want_free ? !mir_used[idx] : (mir_used[idx] && mir_key[idx] == key))
            begin
                where = idx;
                return 1'b1;
            end
            idx = (idx + stride) % n;
        end
        return 1'b0;
    endfunction

    function automatic lookup_rsp_t apply_request(lookup_req_t r);
        lookup_rsp_t res;
        int unsigned where;
        res = '{ST_NOT_FOUND, 32'd0, 10'd0};
        case (r.op)
            OP_SEARCH:
                if (probe_chain(r.key, 1'b0, where))
                    res = '{ST_OK, mir_val[where], where[9:0]};
            OP_INSERT:
                if (probe_chain(r.key, 1'b0, where))
                    res = '{ST_DUPLICATE, 32'd0, where[9:0]};
                else if (probe_chain(r.key, 1'b1, where))
                begin
                    mir_used[where] = 1'b1;
                    mir_key[where]  = r.key;
                    mir_val[where]  = r.value;
                    if (mir_count < 2047) mir_count++;
                    res = '{ST_OK, 32'd0, where[9:0]};
                end
                else
                    res.status = ST_FULL;
            OP_DELETE:
                if (probe_chain(r.key, 1'b0, where))
                begin
                    mir_used[where] = 1'b0;
                    if (mir_count > 0) mir_count--;
                    res = '{ST_OK, 32'd0, where[9:0]};
                end
            default: ;  // unknown code: nothing found, nothing changes
        endcase
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int draw_gap();
        int p;
        if (!idle_on) return 0;
        p = $urandom_range(99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(3, 1);
        if (p < 98) return $urandom_range(15, 4);
        return $urandom_range(80, 20);
    endfunction

    // Request driver: holds an item until transferred, then the next after a gap.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_gap = 0;
        end
        else if (!(req_ch.valid && !req_ch.ready))
        begin
            lookup_req_t nxt;
            if (req_ch.valid)
            begin
                expected_rsps.push_back(apply_request('{req_ch.operation, req_ch.key,
                                                        req_ch.value}));
                n_req++;
            end
            if (req_gap > 0)
            begin
                req_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                nxt = pending_reqs.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.operation <= nxt.op;
                req_ch.key       <= nxt.key;
                req_ch.value     <= nxt.value;
                req_gap = draw_gap();
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Response monitor: checks each transfer against the oldest expectation,
    // and throttles ready with random stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_stall = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                lookup_rsp_t want;
                n_rsp++;
                if (expected_rsps.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= SHOW_MAX)
                        $display("%0t: result with nothing expected: st=%0d val=%h slot=%0d",
                                 $realtime, rsp_ch.status, rsp_ch.found_value, rsp_ch.slot);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    case (want.status)
                        ST_FULL:      n_full++;
                        ST_DUPLICATE: n_dup++;
                        ST_NOT_FOUND: n_miss++;
                        default:      n_hit++;
                    endcase
                    if (rsp_ch.status !== want.status || rsp_ch.found_value !== want.found_value
                        || rsp_ch.slot !== want.slot)
                    begin
                        n_bad++;
                        if (n_bad <= SHOW_MAX)
                            $display("%0t: mismatch exp st=%0d val=%h slot=%0d got st=%0d val=%h slot=%0d",
                                     $realtime, want.status, want.found_value, want.slot,
                                     rsp_ch.status, rsp_ch.found_value, rsp_ch.slot);
                    end
                end
            end
            if (rsp_stall > 0)
            begin
                rsp_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                rsp_stall = draw_gap();
            end
        end
    end

    // Watchdog: cycles without any transfer on any channel.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, expected_rsps.size());
            $display("[double_hash_table_core] ERROR");
            $finish;
        end
    end

    task automatic push_req(logic [1:0] op, logic [31:0] key, logic [31:0] value);
        pending_reqs.push_back('{op, key, value});
    endtask

    // Let everything queued transfer and every result return.
    task automatic drain();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_size(logic [10:0] sz);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= sz;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        mir_size = sz;
    endtask

    // One random phase over a pool of keys small enough to collide, fill
    // a small table and hit duplicates; a few keys are fully random.
    task automatic random_phase(logic [10:0] sz, int n_items, bit quiet);
        logic [31:0] pool[$];
        int unsigned n, pool_len, p;
        logic [1:0] op;
        logic [31:0] key;
        write_size(sz);
        idle_on  = !quiet;
        n        = slots_in_use();
        pool_len = (n + n / 2 + 2 > 40) ? 40 : n + n / 2 + 2;
        for (int i = 0; i < pool_len; i++)
            pool.push_back($urandom());
        for (int i = 0; i < n_items; i++)
        begin
            p  = $urandom_range(99);
            op = (p < 45) ? OP_INSERT : (p < 70) ? OP_SEARCH : (p < 95) ? OP_DELETE : 2'd3;
            key = ($urandom_range(9) == 0) ? $urandom() : pool[$urandom_range(pool_len - 1)];
            push_req(op, key, $urandom());
        end
        drain();
        idle_on = 1'b1;
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.operation = OP_SEARCH;
        req_ch.key = '0;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        idle_on = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset size, extreme keys and values, every operation.
        push_req(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        push_req(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        push_req(OP_SEARCH, 32'h0000_0000, 32'h0);
        push_req(OP_SEARCH, 32'hFFFF_FFFF, 32'h0);
        push_req(OP_INSERT, 32'h0000_0000, 32'h1234_5678);   // duplicate key
        push_req(OP_SEARCH, 32'h0000_03FD, 32'h0);           // absent key, same home slot
        push_req(OP_INSERT, 32'h0000_03FD, 32'hA5A5_5A5A);   // collides with key 0
        push_req(OP_DELETE, 32'h0000_0000, 32'h0);
        push_req(OP_SEARCH, 32'h0000_03FD, 32'h0);           // still reached past the hole
        push_req(OP_DELETE, 32'h0000_0000, 32'h0);           // already gone
        push_req(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);         // undefined code
        drain();

        // Directed: tiny table, fill to full, then keep the entries across
        // a size change.
        write_size(11'd5);
        for (int i = 0; i < 6; i++)
            push_req(OP_INSERT, 32'(i * 5), $urandom());
        push_req(OP_SEARCH, 32'd20, 32'h0);
        push_req(OP_DELETE, 32'd10, 32'h0);
        push_req(OP_INSERT, 32'd99, 32'hDEAD_BEEF);
        drain();

        random_phase(11'd7,    60, 1'b0);
        random_phase(11'd13,   60, 1'b1);
        random_phase(11'd0,    40, 1'b0);   // saturates to the minimum
        random_phase(11'd4,    40, 1'b0);   // not prime: chains miss slots
        random_phase(11'd97,   60, 1'b0);
        random_phase(11'd2047, 15, 1'b0);   // saturates to the full depth
        random_phase(11'd31,   60, 1'b1);
        random_phase(11'd3,    40, 1'b0);
        random_phase(11'd1021, 12, 1'b0);
        random_phase(11'd11,   50, 1'b0);

        repeat (50) @(posedge clk);
        $display("covered %0d requests over 12 size settings: %0d hits, %0d misses,",
                 n_req, n_hit, n_miss);
        $display("%0d duplicates, %0d full; %0d results checked, %0d mismatches",
                 n_dup, n_full, n_rsp, n_bad);
        if (n_bad == 0 && expected_rsps.size() == 0)
            $display("[double_hash_table_core] OK");
        else
            $display("[double_hash_table_core] ERROR");
        $finish;
    end

endmodule

// ----- double_hash_table_core.f -----
src/dht_pkg.sv
src/dht_ifs.sv
src/dht_ram.sv
src/dht_queue.sv
src/dht_front.sv
src/dht_back.sv
src/double_hash_table_core.sv
src/dht_checker.sv
dv/tb_top.sv
